[hdl/cpcr_pkg.sv]
`default_nettype none
package cpcr_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RadW     = 31;
  localparam int unsigned MassW    = 16;
  localparam int unsigned DiffW    = CoordW + 1;        // dx, dy
  localparam int unsigned SqW      = 2 * DiffW;         // dx^2 + dy^2
  localparam int unsigned DistW    = SqW / 2;           // integer root
  localparam int unsigned UnitFrac = 30;                // q2.30 unit vector
  localparam int unsigned UnitQW   = UnitFrac + 1;
  localparam int unsigned UnitNW   = DiffW + UnitFrac;
  localparam int unsigned WideW    = 36;                // signed working width
  localparam int unsigned SatW     = WideW + 2;
  localparam int unsigned MsumW    = MassW + 1;
  localparam int unsigned NumPW    = 54;                // signed mass numerator
  localparam int unsigned MnumW    = 52;                // its magnitude
  localparam int unsigned MqW      = 35;                // mass quotient bits

  typedef logic signed [WideW-1:0] wide_t;
  typedef logic signed [NumPW-1:0] mnum_t;

  typedef struct packed {
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
    logic signed [CoordW-1:0] first_vel_x;
    logic signed [CoordW-1:0] first_vel_y;
    logic        [RadW-1:0]   first_radius;
    logic        [MassW-1:0]  first_mass;
    logic signed [CoordW-1:0] second_x;
    logic signed [CoordW-1:0] second_y;
    logic signed [CoordW-1:0] second_vel_x;
    logic signed [CoordW-1:0] second_vel_y;
    logic        [RadW-1:0]   second_radius;
    logic        [MassW-1:0]  second_mass;
  } pair_t;

  typedef struct packed {
    logic signed [CoordW-1:0] new_first_x;
    logic signed [CoordW-1:0] new_first_y;
    logic signed [CoordW-1:0] new_second_x;
    logic signed [CoordW-1:0] new_second_y;
    logic signed [CoordW-1:0] new_first_vel_x;
    logic signed [CoordW-1:0] new_first_vel_y;
    logic signed [CoordW-1:0] new_second_vel_x;
    logic signed [CoordW-1:0] new_second_vel_y;
    logic                     degenerate;
  } result_t;

  // carried alongside the root extraction
  typedef struct packed {
    pair_t            item;
    logic             neg_dx;
    logic             neg_dy;
    logic [DiffW-1:0] mag_dx;
    logic [DiffW-1:0] mag_dy;
  } geo_t;

  // carried alongside the unit vector division
  typedef struct packed {
    pair_t            item;
    logic             neg_dx;
    logic             neg_dy;
    logic [DistW-1:0] span;
  } unit_side_t;

  // working set of the back half of the pipeline
  typedef struct packed {
    pair_t                    item;
    logic                     degen;
    logic                     neg_k1;
    logic                     neg_k2;
    wide_t                    sep;
    wide_t                    nx;
    wide_t                    ny;
    logic signed [CoordW-1:0] px1;
    logic signed [CoordW-1:0] py1;
    logic signed [CoordW-1:0] px2;
    logic signed [CoordW-1:0] py2;
    wide_t                    dn1;
    wide_t                    dn2;
    wide_t                    dt1;
    wide_t                    dt2;
    wide_t                    k1;
    wide_t                    k2;
  } work_t;

  // sign(a*b) * trunc(|a|*|b| / 2^sh)
  function automatic wide_t mulsh(input wide_t a, input wide_t b, input int unsigned sh);
    logic [WideW-1:0]   ma;
    logic [WideW-1:0]   mb;
    logic [2*WideW-1:0] p;
    logic [WideW-1:0]   q;
    ma = a[WideW-1] ? WideW'(-a) : WideW'(a);
    mb = b[WideW-1] ? WideW'(-b) : WideW'(b);
    p  = (2*WideW)'(ma) * (2*WideW)'(mb);
    q  = WideW'(p >> sh);
    return (a[WideW-1] ^ b[WideW-1]) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(32'sh7fff_ffff);
    lo = -hi - SatW'(1);
    if (v > hi) return hi[CoordW-1:0];
    else if (v < lo) return lo[CoordW-1:0];
    else return v[CoordW-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/cpcr_pair_if.sv]
`default_nettype none
interface cpcr_pair_if
  import cpcr_pkg::*;
();
  logic  valid;
  logic  ready;
  pair_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/cpcr_result_if.sv]
`default_nettype none
interface cpcr_result_if
  import cpcr_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/cpcr_isqrt.sv]
`default_nettype none
// pipelined integer square root, one root bit per stage
module cpcr_isqrt #(
  parameter int unsigned RadBits  = 66,
  parameter int unsigned SideBits = 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_vld,
  input  wire [RadBits-1:0]   rad,
  input  wire [SideBits-1:0]  side_in,
  output logic                out_vld,
  output logic [RadBits/2-1:0] root,
  output logic [SideBits-1:0] side_out
);

  localparam int unsigned RootW = RadBits / 2;
  localparam int unsigned RemW  = RootW + 3;

  logic                vld_q  [RootW];
  logic [RemW-1:0]     rem_q  [RootW];
  logic [RootW-1:0]    root_q [RootW];
  logic [RadBits-1:0]  rad_q  [RootW];
  logic [SideBits-1:0] side_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic                vld_in;
    logic [RemW-1:0]     rem_in;
    logic [RootW-1:0]    root_in;
    logic [RadBits-1:0]  rad_in;
    logic [SideBits-1:0] side_k;
    logic [RemW-1:0]     rem_sh;
    logic [RemW-1:0]     trial;
    logic [RemW-1:0]     rem_nx;
    logic [RootW-1:0]    root_nx;

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = in_vld;
        rem_in  = '0;
        root_in = '0;
        rad_in  = rad;
        side_k  = side_in;
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        rad_in  = rad_q[k-1];
        side_k  = side_q[k-1];
      end
    end

    always_comb begin
      rem_sh = {rem_in[RemW-3:0], rad_in[RadBits-1-2*k -: 2]};
      trial  = RemW'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nx  = rem_sh - trial;
        root_nx = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_nx  = rem_sh;
        root_nx = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= rem_nx;
        root_q[k] <= root_nx;
        rad_q[k]  <= rad_in;
        side_q[k] <= side_k;
      end
    end
  end

  assign out_vld  = vld_q[RootW-1];
  assign root     = root_q[RootW-1];
  assign side_out = side_q[RootW-1];

endmodule
`default_nettype wire

[hdl/cpcr_udiv.sv]
`default_nettype none
// pipelined restoring divider, two numerators over one divisor,
// one quotient bit per stage
module cpcr_udiv #(
  parameter int unsigned NumBits  = 8,
  parameter int unsigned DenBits  = 8,
  parameter int unsigned QuoBits  = 4,
  parameter int unsigned SideBits = 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_vld,
  input  wire [NumBits-1:0]   num0,
  input  wire [NumBits-1:0]   num1,
  input  wire [DenBits-1:0]   den,
  input  wire [SideBits-1:0]  side_in,
  output logic                out_vld,
  output logic [QuoBits-1:0]  quo0,
  output logic [QuoBits-1:0]  quo1,
  output logic [SideBits-1:0] side_out
);

  logic                vld_q  [QuoBits];
  logic [DenBits-1:0]  den_q  [QuoBits];
  logic [NumBits-1:0]  num_q  [QuoBits][2];
  logic [DenBits-1:0]  rem_q  [QuoBits][2];
  logic [QuoBits-1:0]  quo_q  [QuoBits][2];
  logic [SideBits-1:0] side_q [QuoBits];

  for (genvar k = 0; k < QuoBits; k++) begin : g_step
    logic                vld_in;
    logic [DenBits-1:0]  den_in;
    logic [NumBits-1:0]  num_in [2];
    logic [DenBits-1:0]  rem_in [2];
    logic [QuoBits-1:0]  quo_in [2];
    logic [SideBits-1:0] side_k;
    logic [DenBits:0]    sh     [2];
    logic [DenBits-1:0]  rem_nx [2];
    logic [QuoBits-1:0]  quo_nx [2];

    if (k == 0) begin : g_first
      // quotient fits QuoBits, so the bits above it start below the divisor
      always_comb begin
        vld_in    = in_vld;
        den_in    = den;
        side_k    = side_in;
        num_in[0] = num0;
        num_in[1] = num1;
        rem_in[0] = DenBits'(num0 >> QuoBits);
        rem_in[1] = DenBits'(num1 >> QuoBits);
        quo_in[0] = '0;
        quo_in[1] = '0;
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_q[k-1];
        den_in = den_q[k-1];
        side_k = side_q[k-1];
        num_in = num_q[k-1];
        rem_in = rem_q[k-1];
        quo_in = quo_q[k-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        sh[l] = {rem_in[l], num_in[l][QuoBits-1-k]};
        if (sh[l] >= {1'b0, den_in}) begin
          rem_nx[l] = DenBits'(sh[l] - {1'b0, den_in});
          quo_nx[l] = {quo_in[l][QuoBits-2:0], 1'b1};
        end else begin
          rem_nx[l] = sh[l][DenBits-1:0];
          quo_nx[l] = {quo_in[l][QuoBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k]  <= den_in;
        side_q[k] <= side_k;
        num_q[k]  <= num_in;
        rem_q[k]  <= rem_nx;
        quo_q[k]  <= quo_nx;
      end
    end
  end

  assign out_vld  = vld_q[QuoBits-1];
  assign quo0     = quo_q[QuoBits-1][0];
  assign quo1     = quo_q[QuoBits-1][1];
  assign side_out = side_q[QuoBits-1];

endmodule
`default_nettype wire

[hdl/circle_pair_collision_resolver.sv]
// throughput: one pair per cycle; the whole pipeline advances together and
// holds while a finished result waits, so nothing is lost or repeated
// depth is set by the 33-stage root, the 31-stage unit divider and the
// 35-stage mass divider, one bit per stage each
// reset (synchronous, active high) clears every stage valid bit and the output valid
`default_nettype none
module circle_pair_collision_resolver
  import cpcr_pkg::*;
(
  input wire             clk,
  input wire             rst,
  cpcr_pair_if.sink      pair,
  cpcr_result_if.source  result
);

  logic    en;
  logic    out_vld;
  result_t out_data;

  assign en           = !out_vld || result.ready;
  assign pair.ready   = en;
  assign result.valid = out_vld;
  assign result.data  = out_data;

  // stage a: centre differences
  logic                    a_vld;
  geo_t                    a_geo;
  geo_t                    a_geo_next;
  logic signed [DiffW-1:0] dx;
  logic signed [DiffW-1:0] dy;

  always_comb begin
    dx = DiffW'(pair.data.first_x) - DiffW'(pair.data.second_x);
    dy = DiffW'(pair.data.first_y) - DiffW'(pair.data.second_y);
    a_geo_next.item   = pair.data;
    a_geo_next.neg_dx = dx[DiffW-1];
    a_geo_next.neg_dy = dy[DiffW-1];
    a_geo_next.mag_dx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    a_geo_next.mag_dy = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
  end

  // stage b: squares, stage c: sum
  logic             b_vld;
  geo_t             b_geo;
  logic [SqW-1:0]   b_sqx;
  logic [SqW-1:0]   b_sqy;
  logic             c_vld;
  geo_t             c_geo;
  logic [SqW-1:0]   c_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else if (en) begin
      a_vld <= pair.valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_geo <= a_geo_next;
      b_geo <= a_geo;
      b_sqx <= SqW'(a_geo.mag_dx) * SqW'(a_geo.mag_dx);
      b_sqy <= SqW'(a_geo.mag_dy) * SqW'(a_geo.mag_dy);
      c_geo <= b_geo;
      c_rad <= b_sqx + b_sqy;
    end
  end

  // centre distance
  logic                     s_vld;
  logic [DistW-1:0]         s_root;
  logic [$bits(geo_t)-1:0]  s_side;
  geo_t                     s_geo;

  cpcr_isqrt #(
    .RadBits  (SqW),
    .SideBits ($bits(geo_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (c_vld),
    .rad      (c_rad),
    .side_in  (c_geo),
    .out_vld  (s_vld),
    .root     (s_root),
    .side_out (s_side)
  );

  assign s_geo = s_side;

  // unit vector components |d.|*2^30 / distance
  unit_side_t                    u_in;
  logic                          u_vld;
  logic [UnitQW-1:0]             u_qx;
  logic [UnitQW-1:0]             u_qy;
  logic [$bits(unit_side_t)-1:0] u_side_raw;
  unit_side_t                    u_side;

  always_comb begin
    u_in.item   = s_geo.item;
    u_in.neg_dx = s_geo.neg_dx;
    u_in.neg_dy = s_geo.neg_dy;
    u_in.span   = s_root;
  end

  cpcr_udiv #(
    .NumBits  (UnitNW),
    .DenBits  (DistW),
    .QuoBits  (UnitQW),
    .SideBits ($bits(unit_side_t))
  ) u_unit_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_vld),
    .num0     ({s_geo.mag_dx, {UnitFrac{1'b0}}}),
    .num1     ({s_geo.mag_dy, {UnitFrac{1'b0}}}),
    .den      (s_root),
    .side_in  (u_in),
    .out_vld  (u_vld),
    .quo0     (u_qx),
    .quo1     (u_qy),
    .side_out (u_side_raw)
  );

  assign u_side = u_side_raw;

  // p1: normal (from first towards second) and signed separation
  logic  p1_vld;
  work_t w1;
  work_t w1_next;
  wide_t ux;
  wide_t uy;

  always_comb begin
    ux = WideW'(u_qx);
    uy = WideW'(u_qy);
    w1_next       = '0;
    w1_next.item  = u_side.item;
    w1_next.degen = (u_side.span == '0);
    w1_next.nx    = u_side.neg_dx ? ux : -ux;
    w1_next.ny    = u_side.neg_dy ? uy : -uy;
    w1_next.sep   = WideW'(u_side.span) - WideW'(u_side.item.first_radius)
                    - WideW'(u_side.item.second_radius);
  end

  // p2: correction and projection products
  logic  p2_vld;
  work_t w2;
  wide_t p2_cx;
  wide_t p2_cy;
  wide_t p2_e [4];
  wide_t p2_f [4];

  // p3: projections and separated positions
  logic  p3_vld;
  work_t w3;
  work_t w3_next;

  always_comb begin
    w3_next     = w2;
    w3_next.dn1 = p2_e[0] + p2_e[1];
    w3_next.dn2 = p2_e[2] + p2_e[3];
    w3_next.dt1 = p2_f[0] - p2_f[1];
    w3_next.dt2 = p2_f[2] - p2_f[3];
    // correction is along the normal, so first gains and second loses
    if (w2.degen) begin
      w3_next.px1 = w2.item.first_x;
      w3_next.py1 = w2.item.first_y;
      w3_next.px2 = w2.item.second_x;
      w3_next.py2 = w2.item.second_y;
    end else begin
      w3_next.px1 = sat32(SatW'(w2.item.first_x) + SatW'(p2_cx));
      w3_next.py1 = sat32(SatW'(w2.item.first_y) + SatW'(p2_cy));
      w3_next.px2 = sat32(SatW'(w2.item.second_x) - SatW'(p2_cx));
      w3_next.py2 = sat32(SatW'(w2.item.second_y) - SatW'(p2_cy));
    end
  end

  // p4: mass numerator products
  logic                    p4_vld;
  work_t                   w4;
  mnum_t                   p4_g [4];
  logic signed [MsumW-1:0] md12;
  logic signed [MsumW-1:0] md21;
  logic signed [MsumW:0]   tw1;
  logic signed [MsumW:0]   tw2;

  always_comb begin
    md12 = MsumW'(w3.item.first_mass) - MsumW'(w3.item.second_mass);
    md21 = MsumW'(w3.item.second_mass) - MsumW'(w3.item.first_mass);
    tw1  = {1'b0, w3.item.first_mass, 1'b0};
    tw2  = {1'b0, w3.item.second_mass, 1'b0};
  end

  // p5: numerator sums as sign and magnitude
  logic             p5_vld;
  work_t            w5;
  work_t            w5_next;
  mnum_t            n1;
  mnum_t            n2;
  logic [MnumW-1:0] p5_mag1;
  logic [MnumW-1:0] p5_mag2;
  logic [MsumW-1:0] p5_msum;

  always_comb begin
    n1 = p4_g[0] + p4_g[1];
    n2 = p4_g[2] + p4_g[3];
    w5_next        = w4;
    w5_next.neg_k1 = n1[NumPW-1];
    w5_next.neg_k2 = n2[NumPW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= u_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1      <= w1_next;
      w2      <= w1;
      p2_cx   <= mulsh(w1.sep, w1.nx, 31);
      p2_cy   <= mulsh(w1.sep, w1.ny, 31);
      p2_e[0] <= mulsh(WideW'(w1.item.first_vel_x), w1.nx, UnitFrac);
      p2_e[1] <= mulsh(WideW'(w1.item.first_vel_y), w1.ny, UnitFrac);
      p2_e[2] <= mulsh(WideW'(w1.item.second_vel_x), w1.nx, UnitFrac);
      p2_e[3] <= mulsh(WideW'(w1.item.second_vel_y), w1.ny, UnitFrac);
      p2_f[0] <= mulsh(WideW'(w1.item.first_vel_y), w1.nx, UnitFrac);
      p2_f[1] <= mulsh(WideW'(w1.item.first_vel_x), w1.ny, UnitFrac);
      p2_f[2] <= mulsh(WideW'(w1.item.second_vel_y), w1.nx, UnitFrac);
      p2_f[3] <= mulsh(WideW'(w1.item.second_vel_x), w1.ny, UnitFrac);
      w3      <= w3_next;
      w4      <= w3;
      p4_g[0] <= NumPW'(w3.dn1) * NumPW'(md12);
      p4_g[1] <= NumPW'(w3.dn2) * NumPW'(tw2);
      p4_g[2] <= NumPW'(w3.dn2) * NumPW'(md21);
      p4_g[3] <= NumPW'(w3.dn1) * NumPW'(tw1);
      w5      <= w5_next;
      p5_mag1 <= MnumW'(n1[NumPW-1] ? -n1 : n1);
      p5_mag2 <= MnumW'(n2[NumPW-1] ? -n2 : n2);
      p5_msum <= MsumW'(w4.item.first_mass) + MsumW'(w4.item.second_mass);
    end
  end

  // normal components after the exchange
  logic                     m_vld;
  logic [MqW-1:0]           m_q1;
  logic [MqW-1:0]           m_q2;
  logic [$bits(work_t)-1:0] m_side_raw;
  work_t                    m_side;

  cpcr_udiv #(
    .NumBits  (MnumW),
    .DenBits  (MsumW),
    .QuoBits  (MqW),
    .SideBits ($bits(work_t))
  ) u_mass_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p5_vld),
    .num0     (p5_mag1),
    .num1     (p5_mag2),
    .den      (p5_msum),
    .side_in  (w5),
    .out_vld  (m_vld),
    .quo0     (m_q1),
    .quo1     (m_q2),
    .side_out (m_side_raw)
  );

  assign m_side = m_side_raw;

  // p6: signed k, both masses zero keeps the normal components
  logic  p6_vld;
  work_t w6;
  work_t w6_next;
  wide_t q1w;
  wide_t q2w;
  logic  mzero;

  always_comb begin
    q1w   = WideW'(m_q1);
    q2w   = WideW'(m_q2);
    mzero = (m_side.item.first_mass == '0) && (m_side.item.second_mass == '0);
    w6_next = m_side;
    if (mzero) begin
      w6_next.k1 = m_side.dn1;
      w6_next.k2 = m_side.dn2;
    end else begin
      w6_next.k1 = m_side.neg_k1 ? -q1w : q1w;
      w6_next.k2 = m_side.neg_k2 ? -q2w : q2w;
    end
  end

  // p7: rebuild products, p8: sums into the output register
  logic    p7_vld;
  work_t   w7;
  wide_t   p7_h [8];
  result_t out_next;

  always_comb begin
    out_next.new_first_x  = w7.px1;
    out_next.new_first_y  = w7.py1;
    out_next.new_second_x = w7.px2;
    out_next.new_second_y = w7.py2;
    out_next.degenerate   = w7.degen;
    if (w7.degen) begin
      out_next.new_first_vel_x  = w7.item.first_vel_x;
      out_next.new_first_vel_y  = w7.item.first_vel_y;
      out_next.new_second_vel_x = w7.item.second_vel_x;
      out_next.new_second_vel_y = w7.item.second_vel_y;
    end else begin
      out_next.new_first_vel_x  = sat32(SatW'(p7_h[0]) - SatW'(p7_h[1]));
      out_next.new_first_vel_y  = sat32(SatW'(p7_h[2]) + SatW'(p7_h[3]));
      out_next.new_second_vel_x = sat32(SatW'(p7_h[4]) - SatW'(p7_h[5]));
      out_next.new_second_vel_y = sat32(SatW'(p7_h[6]) + SatW'(p7_h[7]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_vld  <= 1'b0;
      p7_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      p6_vld  <= m_vld;
      p7_vld  <= p6_vld;
      out_vld <= p7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w6       <= w6_next;
      w7       <= w6;
      p7_h[0]  <= mulsh(w6.nx, w6.k1, UnitFrac);
      p7_h[1]  <= mulsh(w6.ny, w6.dt1, UnitFrac);
      p7_h[2]  <= mulsh(w6.ny, w6.k1, UnitFrac);
      p7_h[3]  <= mulsh(w6.nx, w6.dt1, UnitFrac);
      p7_h[4]  <= mulsh(w6.nx, w6.k2, UnitFrac);
      p7_h[5]  <= mulsh(w6.ny, w6.dt2, UnitFrac);
      p7_h[6]  <= mulsh(w6.ny, w6.k2, UnitFrac);
      p7_h[7]  <= mulsh(w6.nx, w6.dt2, UnitFrac);
      out_data <= out_next;
    end
  end

endmodule
`default_nettype wire

[hdl/cpcr_chk.sv]
`default_nettype none
module cpcr_chk
  import cpcr_pkg::*;
(
  input wire     clk,
  input wire     rst,
  input wire     in_ready,
  input wire     out_valid,
  input wire     out_ready,
  input result_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side stalls only behind a waiting result
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind circle_pair_collision_resolver cpcr_chk u_cpcr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
`default_nettype wire
